// ===== rtl/fire_heat_column_core_defines.svh =====
// assertion macros for the fire heat column core
`ifndef FIRE_HEAT_COLUMN_CORE_DEFINES_SVH
`define FIRE_HEAT_COLUMN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check that holds only outside reset
`define FHC_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fire heat column check failed");
// check that holds during reset too
`define FHC_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fire heat column reset check failed");
`else
`define FHC_CHECK(lbl, prop)
`define FHC_CHECK_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/fhc_pkg.sv =====
package fhc_pkg;

    // column height in heat cells
    localparam int CELLS  = 16;
    localparam int CELL_W = $clog2(CELLS);

    localparam int HEAT_W = 8;
    localparam int ROW_W  = 4;
    localparam int MUL_W  = 16;
    localparam int PROD_W = 2 * MUL_W;

    // floor(s/3) for s < 768: (s*683) >> 11
    localparam logic [MUL_W-1:0] DIV3_MUL   = 16'd683;
    localparam int               DIV3_SHIFT = 11;

    // t = (h*191 + 127) / 255, division as (x*32897) >> 23 for x < 48833
    localparam logic [MUL_W-1:0] HEAT_SCALE   = 16'd191;
    localparam logic [MUL_W-1:0] HEAT_ROUND   = 16'd127;
    localparam logic [MUL_W-1:0] DIV255_MUL   = 16'd32897;
    localparam int               DIV255_SHIFT = 23;

    localparam logic [7:0] PAL_HIGH = 8'h80;
    localparam logic [7:0] PAL_MID  = 8'h40;
    localparam logic [7:0] CHAN_MAX = 8'hFF;

    localparam logic [7:0] THRESHOLD_RESET = 8'd50;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COOL,
        ST_DIFF_A,
        ST_DIFF_B,
        ST_DIFF_W,
        ST_SPARK_RD,
        ST_SPARK,
        ST_COL_RD,
        ST_COL_M1,
        ST_COL_M2,
        ST_COL_OUT
    } t_fhc_state;

endpackage

// ===== rtl/fire_heat_column_core.sv =====
// Fire heat column core: one column of a fire effect. A frame is CELLS input transactions,
// one per heat cell in order 0..CELLS-1; each lowers its cell's heat by the cooldown,
// flooring at zero. The last transaction of a frame also lets the heat drift upward
// (h[k] = (h[k-1] + 2*h[k-2]) / 3 for k from CELLS-1 down to 2), adds spark_add to cell
// spark_row (mod 256) when spark_draw < spark_threshold and the row is inside the column,
// and then emits CELLS colour transactions, row 0 first, frame_end on the last. Heat maps
// to t = round(h*191/255) and a three-band red/yellow/white palette. A transaction that is
// not the last of a frame reads the heat store, then writes it back; the last one runs the
// cooldown, the diffusion, the spark and then the colours, which wait on an output stall.
// All multiplications go through one 16x16 multiplier with a registered product, and all
// heat reads through the single read port of the heat store. The input is stalled whenever
// the core is not idle; the last colour sits in the output register, so the next frame can
// start while it waits. The heat store clears at reset at once through per-cell valid bits;
// spark_threshold resets to 50 and is written through i_cfg_we / i_cfg_data. The user must
// write it only while the core is idle; the core itself does not enforce this.
`include "fire_heat_column_core_defines.svh"

module fire_heat_column_core
    import fhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // configuration
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,

    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [5:0]        i_cooldown,
    input  logic [7:0]        i_spark_draw,
    input  logic [2:0]        i_spark_row,
    input  logic [7:0]        i_spark_add,

    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ROW_W-1:0]  o_row,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic              o_frame_end
);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_fhc_state          r_state, n_state;

    logic [7:0]          r_threshold;
    logic [CELL_W-1:0]   r_cell_cnt, n_cell_cnt;   // next cell expected in the frame
    logic [CELL_W-1:0]   r_k, n_k;                 // diffusion / colour cell index

    // fields of the transaction at work
    logic [5:0]          r_cool;
    logic [7:0]          r_draw;
    logic [2:0]          r_srow;
    logic [7:0]          r_sadd;

    // heat store: one write and one registered read port
    logic [HEAT_W-1:0]   mem_heat [CELLS];
    logic [CELLS-1:0]    r_heat_vld;               // cleared at reset, unwritten reads as 0
    logic [HEAT_W-1:0]   r_rd_data;
    logic                r_rd_vld;
    logic [CELL_W-1:0]   rd_addr;
    logic [HEAT_W-1:0]   rd_heat;

    logic                wr_en;
    logic [CELL_W-1:0]   wr_addr;
    logic [HEAT_W-1:0]   wr_data;

    // holds h[k-1] across the diffusion sweep
    logic [HEAT_W-1:0]   r_hk1, n_hk1;

    // shared multiplier
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic                mul_en;
    logic [PROD_W-1:0]   r_prod;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [ROW_W-1:0]    r_row;
    logic [7:0]          r_red, r_green, r_blue;
    logic                r_frame_end;
    logic                out_load;

    logic                in_accept;
    logic                spark_hit;
    logic [9:0]          diff_sum;
    logic [7:0]          pal_t;
    logic [7:0]          ramp;
    logic [HEAT_W-1:0]   cool_res;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    assign rd_heat = r_rd_vld ? r_rd_data : '0;

    // cooldown with floor at zero
    assign cool_res = (rd_heat < HEAT_W'(r_cool)) ? '0 : rd_heat - HEAT_W'(r_cool);

    // h[k-1] + 2*h[k-2]
    assign diff_sum = 10'(r_hk1) + {1'b0, rd_heat, 1'b0};

    assign spark_hit = (r_draw < r_threshold) && (int'(r_srow) < CELLS);

    // palette index and ramp from the second product
    assign pal_t = r_prod[DIV255_SHIFT +: 8];
    assign ramp  = {pal_t[5:0], 2'b00};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cell_cnt  = r_cell_cnt;
        n_k         = r_k;
        n_hk1       = r_hk1;
        rd_addr     = r_k;
        wr_en       = 1'b0;
        wr_addr     = r_k;
        wr_data     = rd_heat;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            ST_IDLE: begin
                rd_addr = r_cell_cnt;
                if (in_accept) begin
                    n_state = ST_COOL;
                end
            end
            ST_COOL: begin
                wr_en   = 1'b1;
                wr_addr = r_cell_cnt;
                wr_data = cool_res;
                if (int'(r_cell_cnt) == CELLS - 1) begin
                    // last cell: start the upward drift at the top
                    n_cell_cnt = '0;
                    n_k        = CELL_W'(CELLS - 1);
                    rd_addr    = CELL_W'(CELLS - 2);
                    n_state    = ST_DIFF_A;
                end else begin
                    n_cell_cnt = r_cell_cnt + 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_DIFF_A: begin
                n_hk1   = rd_heat;
                rd_addr = r_k - CELL_W'(2);
                n_state = ST_DIFF_B;
            end
            ST_DIFF_B: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(diff_sum);
                mul_b   = DIV3_MUL;
                n_hk1   = rd_heat;
                n_state = ST_DIFF_W;
            end
            ST_DIFF_W: begin
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = r_prod[DIV3_SHIFT +: HEAT_W];
                if (int'(r_k) == 2) begin
                    n_state = ST_SPARK_RD;
                end else begin
                    rd_addr = r_k - CELL_W'(3);
                    n_k     = r_k - 1'b1;
                    n_state = ST_DIFF_B;
                end
            end
            ST_SPARK_RD: begin
                rd_addr = CELL_W'(r_srow);
                n_state = ST_SPARK;
            end
            ST_SPARK: begin
                wr_en   = spark_hit;
                wr_addr = CELL_W'(r_srow);
                wr_data = rd_heat + r_sadd;
                n_k     = '0;
                n_state = ST_COL_RD;
            end
            ST_COL_RD: begin
                rd_addr = r_k;
                n_state = ST_COL_M1;
            end
            ST_COL_M1: begin
                mul_en  = 1'b1;
                mul_a   = MUL_W'(rd_heat);
                mul_b   = HEAT_SCALE;
                n_state = ST_COL_M2;
            end
            ST_COL_M2: begin
                mul_en  = 1'b1;
                mul_a   = r_prod[MUL_W-1:0] + HEAT_ROUND;
                mul_b   = DIV255_MUL;
                n_state = ST_COL_OUT;
            end
            ST_COL_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    if (int'(r_k) == CELLS - 1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        rd_addr = r_k + 1'b1;
                        n_state = ST_COL_M1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_cnt  <= '0;
            r_threshold <= THRESHOLD_RESET;
            r_heat_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cell_cnt  <= n_cell_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (wr_en) begin
                r_heat_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_hk1 <= n_hk1;
        if (in_accept) begin
            r_cool <= i_cooldown;
            r_draw <= i_spark_draw;
            r_srow <= i_spark_row;
            r_sadd <= i_spark_add;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // heat store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_heat[wr_addr] <= wr_data;
        end
        r_rd_data <= mem_heat[rd_addr];
        r_rd_vld  <= r_heat_vld[rd_addr];
    end

    // colour output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_row       <= ROW_W'(r_k);
            r_frame_end <= (int'(r_k) == CELLS - 1);
            if (pal_t > PAL_HIGH) begin
                r_red   <= CHAN_MAX;
                r_green <= CHAN_MAX;
                r_blue  <= ramp;
            end else if (pal_t > PAL_MID) begin
                r_red   <= CHAN_MAX;
                r_green <= ramp;
                r_blue  <= '0;
            end else begin
                r_red   <= ramp;
                r_green <= '0;
                r_blue  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row       = r_row;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_frame_end = r_frame_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `FHC_CHECK(a_cnt_in_range, int'(r_cell_cnt) < CELLS)
    `FHC_CHECK(a_accept_to_cool, in_accept |=> (r_state == ST_COOL))
    `FHC_CHECK(a_frame_end_row, (o_out_valid && o_frame_end) |-> (int'(o_row) == CELLS - 1))
    `FHC_CHECK(a_load_only_free, out_load |-> (!r_out_valid || !i_out_stall))
    `FHC_CHECK_ALWAYS(a_reset_quiet, !i_rst_n |=> (!o_out_valid && (r_state == ST_IDLE)))

endmodule
